// ===== rtl/core/cdd_pkg.sv =====
// Shared types, op codes and calendar helper functions for the date difference block.
// No dependencies; used by cdd_ctrl, cdd_datapath and calendar_date_difference.
`timescale 1ns / 1ps
`default_nettype none
package cdd_pkg;

  // datapath operations issued by the controller
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
  localparam logic [OP_W-1:0] OP_DIGIT  = 5'd2;
  localparam logic [OP_W-1:0] OP_CHECK  = 5'd3;
  localparam logic [OP_W-1:0] OP_FILL_E = 5'd4;
  localparam logic [OP_W-1:0] OP_FIX_E  = 5'd5;
  localparam logic [OP_W-1:0] OP_FILL_S = 5'd6;
  localparam logic [OP_W-1:0] OP_FIX_S  = 5'd7;
  localparam logic [OP_W-1:0] OP_ORDER  = 5'd8;
  localparam logic [OP_W-1:0] OP_YEARS  = 5'd9;
  localparam logic [OP_W-1:0] OP_ALIGN  = 5'd10;
  localparam logic [OP_W-1:0] OP_DN1    = 5'd11;
  localparam logic [OP_W-1:0] OP_DN2    = 5'd12;
  localparam logic [OP_W-1:0] OP_DN3    = 5'd13;
  localparam logic [OP_W-1:0] OP_DN4    = 5'd14;
  localparam logic [OP_W-1:0] OP_WEEK1  = 5'd15;
  localparam logic [OP_W-1:0] OP_WEEK2  = 5'd16;
  localparam logic [OP_W-1:0] OP_MONTHS = 5'd17;
  localparam logic [OP_W-1:0] OP_MDAY   = 5'd18;
  localparam logic [OP_W-1:0] OP_FINISH = 5'd19;

  // unit codes
  localparam logic [2:0] CMD_DAY   = 3'd0;
  localparam logic [2:0] CMD_WEEK  = 3'd1;
  localparam logic [2:0] CMD_YEAR  = 3'd2;
  localparam logic [2:0] CMD_MONTH = 3'd3;
  localparam logic [2:0] CMD_MD    = 3'd4;
  localparam logic [2:0] CMD_YM    = 3'd5;
  localparam logic [2:0] CMD_YD    = 3'd6;
  localparam logic [2:0] CMD_BAD   = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_YEAR  = 2'd0;
  localparam logic [1:0] CFG_MONTH = 2'd1;
  localparam logic [1:0] CFG_DAY   = 2'd2;

  localparam logic [13:0] TODAY_YEAR_RST  = 14'd2000;
  localparam logic [3:0]  TODAY_MONTH_RST = 4'd1;
  localparam logic [4:0]  TODAY_DAY_RST   = 5'd1;

  localparam int          DIGIT_STEPS = 6;       // 10^7 down to 10^2
  localparam logic [26:0] DATE_MIN    = 27'd101;
  localparam logic [26:0] DATE_MAX    = 27'd99991231;
  localparam logic [18:0] DIV25_K     = 19'd20972; // ceil(2^19/25)
  localparam logic [22:0] DIV7_K      = 23'd4793491; // ceil(2^25/7)

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [2:0]      idx;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       stop;
  } stat_t;

  typedef struct packed {
    logic [3:0]  q;
    logic [26:0] rem;
  } digit_t;

  // leap test for years -1..10000; y%100 handled as y%25 via reciprocal
  function automatic logic is_leap(input logic signed [14:0] y);
    logic [13:0] p;
    logic [27:0] prod;
    logic        div25;
    p     = 14'(16'(y) + 16'd400);
    prod  = 28'(p) * 28'(DIV25_K);
    div25 = prod[18:0] < DIV25_K;
    return div25 ? (p[3:0] == 4'd0) : (p[1:0] == 2'd0);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the month in a March-based year
  function automatic logic [8:0] march_days(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd3:    v = 9'd0;
      4'd4:    v = 9'd31;
      4'd5:    v = 9'd61;
      4'd6:    v = 9'd92;
      4'd7:    v = 9'd122;
      4'd8:    v = 9'd153;
      4'd9:    v = 9'd184;
      4'd10:   v = 9'd214;
      4'd11:   v = 9'd245;
      4'd12:   v = 9'd275;
      4'd1:    v = 9'd306;
      4'd2:    v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // floor(x/25) for x < 3200
  function automatic logic [6:0] div25(input logic [11:0] x);
    logic [26:0] prod;
    prod = 27'(x) * 27'(DIV25_K);
    return prod[25:19];
  endfunction

  function automatic logic [26:0] pow10(input logic [2:0] idx);
    logic [26:0] v;
    case (idx)
      3'd0:    v = 27'd10000000;
      3'd1:    v = 27'd1000000;
      3'd2:    v = 27'd100000;
      3'd3:    v = 27'd10000;
      3'd4:    v = 27'd1000;
      3'd5:    v = 27'd100;
      default: v = 27'd1;
    endcase
    return v;
  endfunction

  // one decimal digit of r at weight pow10(idx), and what is left
  function automatic digit_t digit_step(input logic [26:0] r, input logic [2:0] idx);
    digit_t      d;
    logic [26:0] pw;
    logic [26:0] mul;
    logic [26:0] sub;
    pw  = pow10(idx);
    sub = '0;
    d.q = '0;
    for (int c = 1; c <= 9; c++) begin
      mul = 27'(c) * pw;
      if (r >= mul) begin
        d.q = 4'(c);
        sub = mul;
      end
    end
    d.rem = r - sub;
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cdd_ctrl.sv =====
// Sequencer for the date difference block: walks parse, fill, order and unit steps.
// Depends on cdd_pkg for op codes and the control/status structs.
`timescale 1ns / 1ps
`default_nettype none
module cdd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire cdd_pkg::stat_t stat,
  output cdd_pkg::ctrl_t     ctl,
  output logic               busy,
  output logic               done
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DIGIT  = 5'd1;
  localparam logic [4:0] S_CHECK  = 5'd2;
  localparam logic [4:0] S_FILLE  = 5'd3;
  localparam logic [4:0] S_FIXE   = 5'd4;
  localparam logic [4:0] S_FILLS  = 5'd5;
  localparam logic [4:0] S_FIXS   = 5'd6;
  localparam logic [4:0] S_ORDER  = 5'd7;
  localparam logic [4:0] S_YEARS  = 5'd8;
  localparam logic [4:0] S_ALIGN  = 5'd9;
  localparam logic [4:0] S_FIXA   = 5'd10;
  localparam logic [4:0] S_DN1    = 5'd11;
  localparam logic [4:0] S_DN2    = 5'd12;
  localparam logic [4:0] S_DN3    = 5'd13;
  localparam logic [4:0] S_DN4    = 5'd14;
  localparam logic [4:0] S_WEEK1  = 5'd15;
  localparam logic [4:0] S_WEEK2  = 5'd16;
  localparam logic [4:0] S_MONTHS = 5'd17;
  localparam logic [4:0] S_MDAY   = 5'd18;
  localparam logic [4:0] S_FINISH = 5'd19;

  logic [4:0] state, state_next;
  logic [2:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= (state == S_FINISH);
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl.op     = cdd_pkg::OP_NONE;
    ctl.idx    = cnt;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.op     = cdd_pkg::OP_LOAD;
          cnt_next   = '0;
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        ctl.op   = cdd_pkg::OP_DIGIT;
        cnt_next = cnt + 3'd1;
        if (cnt == 3'(cdd_pkg::DIGIT_STEPS - 1)) state_next = S_CHECK;
      end
      S_CHECK: begin
        ctl.op     = cdd_pkg::OP_CHECK;
        state_next = S_FILLE;
      end
      S_FILLE: begin
        ctl.op     = cdd_pkg::OP_FILL_E;
        state_next = S_FIXE;
      end
      S_FIXE: begin
        ctl.op     = cdd_pkg::OP_FIX_E;
        state_next = S_FILLS;
      end
      S_FILLS: begin
        ctl.op     = cdd_pkg::OP_FILL_S;
        state_next = S_FIXS;
      end
      S_FIXS: begin
        ctl.op     = cdd_pkg::OP_FIX_S;
        state_next = S_ORDER;
      end
      S_ORDER: begin
        ctl.op = cdd_pkg::OP_ORDER;
        if (stat.stop) begin
          state_next = S_FINISH;
        end else begin
          case (stat.cmd) inside
            cdd_pkg::CMD_YEAR:                    state_next = S_YEARS;
            cdd_pkg::CMD_DAY, cdd_pkg::CMD_WEEK:  state_next = S_DN1;
            cdd_pkg::CMD_MONTH:                   state_next = S_MONTHS;
            default:                              state_next = S_ALIGN;
          endcase
        end
      end
      S_YEARS: begin
        ctl.op     = cdd_pkg::OP_YEARS;
        state_next = S_FINISH;
      end
      S_ALIGN: begin
        ctl.op     = cdd_pkg::OP_ALIGN;
        state_next = S_FIXA;
      end
      S_FIXA: begin
        ctl.op     = cdd_pkg::OP_FIX_S;
        state_next = (stat.cmd == cdd_pkg::CMD_YD) ? S_DN1 : S_MONTHS;
      end
      S_DN1: begin
        ctl.op     = cdd_pkg::OP_DN1;
        state_next = S_DN2;
      end
      S_DN2: begin
        ctl.op     = cdd_pkg::OP_DN2;
        state_next = S_DN3;
      end
      S_DN3: begin
        ctl.op     = cdd_pkg::OP_DN3;
        state_next = S_DN4;
      end
      S_DN4: begin
        ctl.op     = cdd_pkg::OP_DN4;
        state_next = (stat.cmd == cdd_pkg::CMD_WEEK) ? S_WEEK1 : S_FINISH;
      end
      S_WEEK1: begin
        ctl.op     = cdd_pkg::OP_WEEK1;
        state_next = S_WEEK2;
      end
      S_WEEK2: begin
        ctl.op     = cdd_pkg::OP_WEEK2;
        state_next = S_FINISH;
      end
      S_MONTHS: begin
        ctl.op     = cdd_pkg::OP_MONTHS;
        state_next = (stat.cmd == cdd_pkg::CMD_MD) ? S_MDAY : S_FINISH;
      end
      S_MDAY: begin
        ctl.op     = cdd_pkg::OP_MDAY;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctl.op     = cdd_pkg::OP_FINISH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/cdd_datapath.sv =====
// Datapath of the date difference block: decimal parse, checks, year fill,
// day numbers and unit arithmetic. Depends on cdd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdd_datapath (
  input  wire logic                 clk,
  input  wire cdd_pkg::ctrl_t       ctl,
  output cdd_pkg::stat_t            stat,
  input  wire logic [2:0]           cmd,
  input  wire logic [26:0]          from_date,
  input  wire logic [26:0]          to_date,
  input  wire logic [13:0]          today_year,
  input  wire logic [3:0]           today_month,
  input  wire logic [4:0]           today_day,
  output logic signed [22:0]        difference,
  output logic                      error
);

  logic [2:0]         cmd_r;
  logic [26:0]        rs, re;
  logic signed [14:0] sy, ey;
  logic [6:0]         sm, em, sd, ed;
  logic               err, neg;
  logic [22:0]        diff;
  logic [13:0]        yy_s, yy_e;
  logic [8:0]         doy_s, doy_e;
  logic [6:0]         q100_s, q100_e;
  logic [6:0]         q400_s, q400_e;
  logic [22:0]        days_s, days_e;
  logic [44:0]        wprod;

  cdd_pkg::digit_t dig_s, dig_e;
  logic [13:0] ty_c;
  logic [3:0]  tm_c;
  logic [4:0]  td_c;
  logic        today_lt, e_md_lt_s, s_md_gt_e, s_gt_e, keys_eq;
  logic        bad_s, bad_e;
  logic [22:0] dy, months;
  logic [4:0]  midx;
  logic [3:0]  pm;
  logic [4:0]  plen;
  logic [6:0]  sdc;

  assign dig_s = cdd_pkg::digit_step(rs, ctl.idx);
  assign dig_e = cdd_pkg::digit_step(re, ctl.idx);

  // today's date saturated into range
  assign ty_c = (today_year == 14'd0) ? 14'd1 :
                (today_year > 14'd9999) ? 14'd9999 : today_year;
  assign tm_c = (today_month == 4'd0) ? 4'd1 :
                (today_month > 4'd12) ? 4'd12 : today_month;
  assign td_c = (today_day == 5'd0) ? 5'd1 : today_day;

  // month/day comparisons (day < 100, so lexicographic equals mm*100+dd)
  assign today_lt  = (7'(tm_c) < em) || ((7'(tm_c) == em) && (7'(td_c) < ed));
  assign e_md_lt_s = (em < sm) || ((em == sm) && (ed < sd));
  assign s_md_gt_e = (sm > em) || ((sm == em) && (sd > ed));
  assign s_gt_e    = (sy > ey) || ((sy == ey) && s_md_gt_e);
  assign keys_eq   = (sy == ey) && (sm == em) && (sd == ed);

  assign bad_s = (sm < 7'd1) || (sm > 7'd12) || (sd < 7'd1) ||
                 (sd > 7'(cdd_pkg::month_len(cdd_pkg::is_leap(sy), sm[3:0])));
  assign bad_e = (em < 7'd1) || (em > 7'd12) || (ed < 7'd1) ||
                 (ed > 7'(cdd_pkg::month_len(cdd_pkg::is_leap(ey), em[3:0])));

  assign dy     = 23'(ey) - 23'(sy);
  assign months = (dy << 3) + (dy << 2) + 23'(em) - 23'(sm) - 23'(sd > ed);

  // month before the end month, for the month-day unit
  assign midx = 5'(sm) - 5'd1 + diff[4:0];
  assign pm   = (midx >= 5'd12) ? 4'(midx - 5'd11) : 4'(midx + 5'd1);
  assign plen = cdd_pkg::month_len(1'b0, pm);
  assign sdc  = (sd > 7'(plen)) ? 7'(plen) : sd;

  assign stat.cmd  = cmd_r;
  assign stat.stop = err | keys_eq;

  always_ff @(posedge clk) begin
    case (ctl.op)
      cdd_pkg::OP_LOAD: begin
        cmd_r <= cmd;
        rs    <= from_date;
        re    <= to_date;
        sy    <= '0;
        ey    <= '0;
        sm    <= '0;
        em    <= '0;
        sd    <= '0;
        ed    <= '0;
        diff  <= '0;
        neg   <= 1'b0;
        err   <= (cmd == cdd_pkg::CMD_BAD) ||
                 (from_date < cdd_pkg::DATE_MIN) || (from_date > cdd_pkg::DATE_MAX) ||
                 (to_date < cdd_pkg::DATE_MIN) || (to_date > cdd_pkg::DATE_MAX);
      end
      cdd_pkg::OP_DIGIT: begin
        rs <= dig_s.rem;
        re <= dig_e.rem;
        if (ctl.idx < 3'd4) begin
          sy <= (sy <<< 3) + (sy <<< 1) + 15'(dig_s.q);
          ey <= (ey <<< 3) + (ey <<< 1) + 15'(dig_e.q);
        end else begin
          sm <= (sm << 3) + (sm << 1) + 7'(dig_s.q);
          em <= (em << 3) + (em << 1) + 7'(dig_e.q);
        end
        if (ctl.idx == 3'(cdd_pkg::DIGIT_STEPS - 1)) begin
          sd <= dig_s.rem[6:0];
          ed <= dig_e.rem[6:0];
        end
      end
      cdd_pkg::OP_CHECK: begin
        err <= err | bad_s | bad_e;
      end
      cdd_pkg::OP_FILL_E: begin
        if (ey == 15'sd0) begin
          if (sy == 15'sd0) ey <= 15'({1'b0, ty_c}) - 15'(today_lt);
          else              ey <= sy + 15'(e_md_lt_s);
        end
      end
      cdd_pkg::OP_FIX_E: begin
        // a 29 February filled into a common year moves to the 28th
        if (em == 7'd2 && ed == 7'd29 && !cdd_pkg::is_leap(ey)) ed <= 7'd28;
      end
      cdd_pkg::OP_FILL_S: begin
        if (sy == 15'sd0) sy <= ey - 15'(s_md_gt_e);
      end
      cdd_pkg::OP_FIX_S: begin
        if (sm == 7'd2 && sd == 7'd29 && !cdd_pkg::is_leap(sy)) sd <= 7'd28;
      end
      cdd_pkg::OP_ORDER: begin
        neg <= s_gt_e;
        if (s_gt_e) begin
          sy <= ey;
          sm <= em;
          sd <= ed;
          ey <= sy;
          em <= sm;
          ed <= sd;
        end
      end
      cdd_pkg::OP_YEARS: begin
        diff <= dy - 23'(s_md_gt_e);
      end
      cdd_pkg::OP_ALIGN: begin
        sy <= ey - 15'(s_md_gt_e);
      end
      cdd_pkg::OP_DN1: begin
        yy_s  <= 14'(16'(sy) + 16'd400 - 16'(sm <= 7'd2));
        yy_e  <= 14'(16'(ey) + 16'd400 - 16'(em <= 7'd2));
        doy_s <= cdd_pkg::march_days(sm[3:0]) + 9'(sd) - 9'd1;
        doy_e <= cdd_pkg::march_days(em[3:0]) + 9'(ed) - 9'd1;
      end
      cdd_pkg::OP_DN2: begin
        q100_s <= cdd_pkg::div25(yy_s[13:2]);
        q100_e <= cdd_pkg::div25(yy_e[13:2]);
        q400_s <= cdd_pkg::div25(12'(yy_s[13:4]));
        q400_e <= cdd_pkg::div25(12'(yy_e[13:4]));
      end
      cdd_pkg::OP_DN3: begin
        days_s <= 23'(yy_s) * 23'd365 + 23'(yy_s[13:2]) - 23'(q100_s) + 23'(q400_s)
                  + 23'(doy_s);
        days_e <= 23'(yy_e) * 23'd365 + 23'(yy_e[13:2]) - 23'(q100_e) + 23'(q400_e)
                  + 23'(doy_e);
      end
      cdd_pkg::OP_DN4: begin
        diff <= days_e - days_s;
      end
      cdd_pkg::OP_WEEK1: begin
        wprod <= 45'(diff[21:0]) * 45'(cdd_pkg::DIV7_K);
      end
      cdd_pkg::OP_WEEK2: begin
        diff <= 23'(wprod[44:25]);
      end
      cdd_pkg::OP_MONTHS: begin
        diff <= months;
      end
      cdd_pkg::OP_MDAY: begin
        if (sd <= ed) diff <= 23'(ed) - 23'(sd);
        else          diff <= 23'(ed) + 23'(plen) - 23'(sdc);
      end
      cdd_pkg::OP_FINISH: begin
        difference <= err ? 23'sd0 : $signed(neg ? (23'd0 - diff) : diff);
        error      <= err;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/calendar_date_difference.sv =====
// Calendar date difference: signed difference of two YYYYMMDD dates in a chosen unit.
// The steps walked depend on the unit; errors and equal dates skip the unit steps and
// finish after the order step. One word in flight: a new word is taken only while the
// sequencer is idle; busy drops in the done cycle and done pulses for one cycle; the
// receiver cannot stall. Synchronous active-high reset idles the sequencer, sets today
// 2000-01-01. Depends on cdd_pkg, cdd_ctrl and cdd_datapath.
`timescale 1ns / 1ps
`default_nettype none
module calendar_date_difference (
  input  wire logic               clk,
  input  wire logic               rst,
  // command side
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         cmd,
  input  wire logic [26:0]        from_date,
  input  wire logic [26:0]        to_date,
  // result side, no back-pressure
  output logic                    done,
  output logic signed [22:0]      difference,
  output logic                    error,
  // config write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [13:0]        cfg_data
);

  // today's date, used when a date comes without a year
  logic [13:0] today_year;
  logic [3:0]  today_month;
  logic [4:0]  today_day;

  cdd_pkg::ctrl_t ctl;
  cdd_pkg::stat_t stat;
  logic           start_ok;

  // config is always taken; index three is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      today_year  <= cdd_pkg::TODAY_YEAR_RST;
      today_month <= cdd_pkg::TODAY_MONTH_RST;
      today_day   <= cdd_pkg::TODAY_DAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cdd_pkg::CFG_YEAR:  today_year  <= cfg_data;
        cdd_pkg::CFG_MONTH: today_month <= cfg_data[3:0];
        cdd_pkg::CFG_DAY:   today_day   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // a word is taken only while the sequencer is idle
  assign start_ok = start & ~busy;

  cdd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start_ok),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  cdd_datapath u_dp (
    .clk         (clk),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (cmd),
    .from_date   (from_date),
    .to_date     (to_date),
    .today_year  (today_year),
    .today_month (today_month),
    .today_day   (today_day),
    .difference  (difference),
    .error       (error)
  );

endmodule
`default_nettype wire
